### sv/vla_pkg.sv
// Package with the types, constants and register codes of the VIL layer accumulator.
package vla_pkg;

  localparam int unsigned EXP_TABLE_ENTRIES_DEF = 64;

  localparam int unsigned DBZ_W    = 12;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned VIL_W    = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned ROM_W    = 32;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = 24;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned EXPO_W   = 34;
  localparam int unsigned Q_W      = 48;
  localparam int unsigned IE_W     = 6;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [DBZ_W-1:0]   THRESHOLD_RESET = 12'sd0;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 24'd3782387;

  // The exponent is slope * (dbz + 2048) + bias, with bias = (32 << 28) - 2048 * slope.
  localparam logic [MUL_A_W-1:0] EXP_SLOPE_Q24 = 32'd3184726;
  localparam logic [EXPO_W-1:0]  EXP_BIAS      = 34'd2067615744;
  localparam logic [EXPO_W:0]    EXP_ROUND     = 35'd2048;
  localparam logic [IE_W-1:0]    SHIFT_PIVOT   = 6'd54;

  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_SCALE     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP,
    ST_FETCH,
    ST_INTERP,
    ST_HEIGHT,
    ST_ACCUM,
    ST_RES_LO,
    ST_RES_HI
  } state_e;

  typedef enum logic [2:0] {
    MUL_EXP,
    MUL_INTERP,
    MUL_HEIGHT,
    MUL_RES_LO,
    MUL_RES_HI
  } mul_sel_e;

  typedef struct packed {
    logic in_valid;
    logic above;
    logic in_last;
    logic last_held;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic     take;
    mul_sel_e mul_sel;
    logic     ld_expo;
    logic     ld_fetch;
    logic     ld_interp;
    logic     ld_height;
    logic     ld_accum;
    logic     ld_part;
    logic     ld_out;
  } seq_ctl_t;

endpackage

### sv/vil_layer_accumulator.sv
// Top level of the VIL layer accumulator: registers, datapath and output stage.
// A layer above threshold steps through EXP, FETCH, INTERP, HEIGHT and ACCUM states.
// A non-last layer at or below threshold is taken in idle; a last layer passes RES_LO and
// RES_HI, its result loaded once the output is free and held while tready is low.
// The rate is set by the single 32x24 multiplier that serves every sequenced product in turn.
// Asynchronous active-low reset clears column sum, clamp flag, output valid and registers.
module vil_layer_accumulator #(
  parameter int unsigned EXP_TABLE_ENTRIES = vla_pkg::EXP_TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tdata: dbz [11:0], layer_height_m [27:12], zero [31:28]
  input  logic [31:0]                  s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: vil [31:0]
  output logic [vla_pkg::VIL_W-1:0]    m_axis_tdata_o,
  // tuser: saturated [0]
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [vla_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [vla_pkg::PDATA_W-1:0]  pwdata_i,
  output logic [vla_pkg::PDATA_W-1:0]  prdata_o,
  output logic                         pready_o
);
  import vla_pkg::*;

  localparam int unsigned AW = $clog2(EXP_TABLE_ENTRIES);
  localparam int unsigned PW = 16 + AW + 1;

  seq_stat_t stat;
  seq_ctl_t  ctl;

  logic [DBZ_W-1:0]   threshold_q;
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_wr;

  logic [DBZ_W-1:0]    dbz_in;
  logic [HEIGHT_W-1:0] height_in;
  logic [DBZ_W-1:0]    u_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                last_q;
  logic [EXPO_W-1:0]   expo_q;
  logic [ROM_W-1:0]    lo_q;
  logic [ROM_W-1:0]    diff_q;
  logic [15:0]         w_q;
  logic [IE_W-1:0]     ie_q;
  logic [ROM_W-1:0]    m_q;
  logic [Q_W-1:0]      q_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    sum_d;
  logic                clamped_q;
  logic                clamped_d;
  logic [SCALE_W-1:0]  part_q;
  logic [VIL_W-1:0]    vil_q;
  logic                sat_q;
  logic                out_valid_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [EXPO_W:0]    eb_full;
  logic [21:0]        eb;
  logic [PW-1:0]      p;
  logic [AW-1:0]      idx;
  logic [ROM_W-1:0]   rom_lo;
  logic [ROM_W-1:0]   rom_hi;
  logic [SUM_W-1:0]   term;
  logic [SUM_W:0]     sum_add;
  logic [PROD_W-1:0]  res;
  logic               res_over;

  // Configuration port.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      scale_q     <= SCALE_RESET;
    end else if (cfg_wr) begin
      if (paddr_i[2] == REG_THRESHOLD) begin
        threshold_q <= pwdata_i[DBZ_W-1:0];
      end else begin
        scale_q <= pwdata_i[SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr_i[2] == REG_SCALE) begin
      prdata_o = PDATA_W'(scale_q);
    end else begin
      prdata_o = PDATA_W'(threshold_q);
    end
  end

  // Sequencer.
  assign dbz_in    = s_axis_tdata_i[DBZ_W-1:0];
  assign height_in = s_axis_tdata_i[DBZ_W +: HEIGHT_W];

  assign stat.in_valid  = s_axis_tvalid_i;
  assign stat.above     = $signed(dbz_in) > $signed(threshold_q);
  assign stat.in_last   = s_axis_tlast_i;
  assign stat.last_held = last_q;
  assign stat.out_free  = ~out_valid_q | m_axis_tready_i;

  vla_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  assign s_axis_tready_o = ctl.take;

  // Shared multiplier operand selection.
  always_comb begin
    case (ctl.mul_sel)
      MUL_EXP: begin
        mul_a = EXP_SLOPE_Q24;
        mul_b = MUL_B_W'(u_q);
      end
      MUL_INTERP: begin
        mul_a = diff_q;
        mul_b = MUL_B_W'(w_q);
      end
      MUL_HEIGHT: begin
        mul_a = m_q;
        mul_b = MUL_B_W'(height_q);
      end
      MUL_RES_LO: begin
        mul_a = sum_q[31:0];
        mul_b = scale_q;
      end
      MUL_RES_HI: begin
        mul_a = sum_q[63:32];
        mul_b = scale_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vla_mul u_mul (
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Exponent split and table lookup.
  assign eb_full = (EXPO_W + 1)'(expo_q) + EXP_ROUND;
  assign eb      = eb_full[33:12];
  assign p       = PW'(eb[15:0]) * PW'(EXP_TABLE_ENTRIES);
  assign idx     = p[16 +: AW];

  vla_exp_rom #(
    .ENTRIES (EXP_TABLE_ENTRIES)
  ) u_rom (
    .idx_i (idx),
    .lo_o  (rom_lo),
    .hi_o  (rom_hi)
  );

  // Scale by the integer part of the exponent and accumulate with saturation.
  always_comb begin
    if (ie_q >= SHIFT_PIVOT) begin
      term = SUM_W'(q_q) << (ie_q - SHIFT_PIVOT);
    end else begin
      term = SUM_W'(q_q) >> (SHIFT_PIVOT - ie_q);
    end
  end

  assign sum_add  = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(term);
  assign res      = prod + PROD_W'(part_q);
  assign res_over = |res[PROD_W-1:VIL_W];

  always_comb begin
    sum_d     = sum_q;
    clamped_d = clamped_q;
    if (ctl.ld_accum) begin
      if (sum_add[SUM_W]) begin
        sum_d     = '1;
        clamped_d = 1'b1;
      end else begin
        sum_d = sum_add[SUM_W-1:0];
      end
    end else if (ctl.ld_out) begin
      sum_d     = '0;
      clamped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      clamped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q     <= sum_d;
      clamped_q <= clamped_d;
      if (ctl.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.take && s_axis_tvalid_i) begin
      u_q      <= {~dbz_in[DBZ_W-1], dbz_in[DBZ_W-2:0]};
      height_q <= height_in;
      last_q   <= s_axis_tlast_i;
    end
    if (ctl.ld_expo) begin
      expo_q <= prod[EXPO_W-1:0] + EXP_BIAS;
    end
    if (ctl.ld_fetch) begin
      lo_q   <= rom_lo;
      diff_q <= rom_hi - rom_lo;
      w_q    <= p[15:0];
      ie_q   <= eb[21:16];
    end
    if (ctl.ld_interp) begin
      m_q <= lo_q + ROM_W'(prod[PROD_W-1:16]);
    end
    if (ctl.ld_height) begin
      q_q <= prod[Q_W-1:0];
    end
    if (ctl.ld_part) begin
      part_q <= prod[PROD_W-1:VIL_W];
    end
    if (ctl.ld_out) begin
      vil_q <= res_over ? '1 : res[VIL_W-1:0];
      sat_q <= clamped_q | res_over;
    end
  end

  assign m_axis_tdata_o  = vil_q;
  assign m_axis_tuser_o  = sat_q;
  assign m_axis_tvalid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_clamp_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clamped_q |-> (sum_q == '1))
    else $error("Clamp flag set while the column sum is not at its maximum.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ld_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("Result loaded over a result that was not yet transferred.");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.ld_out |=> (sum_q == '0) && !clamped_q)
    else $error("Column state not cleared after a result.");

  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.take && s_axis_tvalid_i && stat.above) |=> !s_axis_tready_o)
    else $error("Input accepted while a layer is still being processed.");
`endif

endmodule

### sv/vla_exp_rom.sv
// Constant exp2 table over the exponent fraction, read at an entry and its neighbor.
module vla_exp_rom #(
  parameter int unsigned ENTRIES = vla_pkg::EXP_TABLE_ENTRIES_DEF
) (
  input  logic [$clog2(ENTRIES)-1:0] idx_i,
  output logic [vla_pkg::ROM_W-1:0]  lo_o,
  output logic [vla_pkg::ROM_W-1:0]  hi_o
);
  import vla_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES + 1);

  logic [ROM_W-1:0] rom [ENTRIES+1];
  logic [IW-1:0]    lo_idx;
  logic [IW-1:0]    hi_idx;

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_entry
    localparam logic [63:0] X   = (64'(i) << 30) / ENTRIES;
    localparam logic [63:0] ARG = (X * LN2_Q30) >> 30;
    localparam logic [63:0] K1  = ((ONE_Q30 * ARG) >> 30) / 1;
    localparam logic [63:0] K2  = ((K1 * ARG) >> 30) / 2;
    localparam logic [63:0] K3  = ((K2 * ARG) >> 30) / 3;
    localparam logic [63:0] K4  = ((K3 * ARG) >> 30) / 4;
    localparam logic [63:0] K5  = ((K4 * ARG) >> 30) / 5;
    localparam logic [63:0] K6  = ((K5 * ARG) >> 30) / 6;
    localparam logic [63:0] K7  = ((K6 * ARG) >> 30) / 7;
    localparam logic [63:0] K8  = ((K7 * ARG) >> 30) / 8;
    localparam logic [63:0] K9  = ((K8 * ARG) >> 30) / 9;
    localparam logic [63:0] K10 = ((K9 * ARG) >> 30) / 10;
    localparam logic [63:0] K11 = ((K10 * ARG) >> 30) / 11;
    localparam logic [63:0] K12 = ((K11 * ARG) >> 30) / 12;
    localparam logic [63:0] K13 = ((K12 * ARG) >> 30) / 13;
    localparam logic [63:0] K14 = ((K13 * ARG) >> 30) / 14;
    localparam logic [63:0] SUM = ONE_Q30 + K1 + K2 + K3 + K4 + K5 + K6 + K7 + K8 + K9
                                  + K10 + K11 + K12 + K13 + K14;
    assign rom[i] = SUM[ROM_W-1:0];
  end

  assign lo_idx = IW'(idx_i);
  assign hi_idx = IW'(idx_i) + IW'(1);
  assign lo_o   = rom[lo_idx];
  assign hi_o   = rom[hi_idx];

endmodule

### sv/vla_mul.sv
// Shared 32 by 24 bit unsigned multiplier.
module vla_mul (
  input  logic [vla_pkg::MUL_A_W-1:0] a_i,
  input  logic [vla_pkg::MUL_B_W-1:0] b_i,
  output logic [vla_pkg::PROD_W-1:0]  prod_o
);
  import vla_pkg::*;

  assign prod_o = PROD_W'(a_i) * PROD_W'(b_i);

endmodule

### sv/vla_seq.sv
// Sequencer that steps one layer through the shared multiplier.
module vla_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vla_pkg::seq_stat_t stat_i,
  output vla_pkg::seq_ctl_t  ctl_o
);
  import vla_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '{take: 1'b0, mul_sel: MUL_EXP, ld_expo: 1'b0, ld_fetch: 1'b0,
                ld_interp: 1'b0, ld_height: 1'b0, ld_accum: 1'b0, ld_part: 1'b0,
                ld_out: 1'b0};
    case (state_q)
      ST_IDLE: begin
        ctl_o.take = 1'b1;
        if (stat_i.in_valid) begin
          if (stat_i.above) begin
            state_d = ST_EXP;
          end else if (stat_i.in_last) begin
            state_d = ST_RES_LO;
          end
        end
      end
      ST_EXP: begin
        ctl_o.mul_sel = MUL_EXP;
        ctl_o.ld_expo = 1'b1;
        state_d       = ST_FETCH;
      end
      ST_FETCH: begin
        ctl_o.ld_fetch = 1'b1;
        state_d        = ST_INTERP;
      end
      ST_INTERP: begin
        ctl_o.mul_sel   = MUL_INTERP;
        ctl_o.ld_interp = 1'b1;
        state_d         = ST_HEIGHT;
      end
      ST_HEIGHT: begin
        ctl_o.mul_sel   = MUL_HEIGHT;
        ctl_o.ld_height = 1'b1;
        state_d         = ST_ACCUM;
      end
      ST_ACCUM: begin
        ctl_o.ld_accum = 1'b1;
        state_d        = stat_i.last_held ? ST_RES_LO : ST_IDLE;
      end
      ST_RES_LO: begin
        ctl_o.mul_sel = MUL_RES_LO;
        ctl_o.ld_part = 1'b1;
        state_d       = ST_RES_HI;
      end
      ST_RES_HI: begin
        ctl_o.mul_sel = MUL_RES_HI;
        if (stat_i.out_free) begin
          ctl_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### tb/sv/vil_column_checker.sv
// Checker for the VIL layer accumulator: watches every channel, predicts each column result and compares.
module vil_column_checker #(
  parameter int unsigned TABLE_N = vla_pkg::EXP_TABLE_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [31:0]                 s_tdata_i,
  input  logic                        s_tlast_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [vla_pkg::VIL_W-1:0]   m_tdata_i,
  input  logic                        m_tuser_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [vla_pkg::PADDR_W-1:0] paddr_i,
  input  logic [vla_pkg::PDATA_W-1:0] pwdata_i,
  input  logic                        pready_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import vla_pkg::*;

  localparam longint unsigned SLOPE_Q24   = 64'd3184726;
  localparam longint unsigned LN2_Q30_C   = 64'd744261118;
  localparam longint unsigned ONE_Q30_C   = 64'd1 << 30;
  localparam longint unsigned VIL_MAX     = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned     SHOWN_LIMIT = 10;
  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};

  typedef struct packed {
    logic [VIL_W-1:0] vil;
    logic             saturated;
  } vil_result_t;

  longint unsigned    exp2_rom [0:TABLE_N];
  logic signed [11:0] threshold_q;
  logic [23:0]        scale_q;
  longint unsigned    column_sum;
  logic               sum_clamped;
  vil_result_t        expected_vil_q [$];
  int unsigned        mismatches = 0;

  assign fail_count_o = mismatches;

  initial begin
    longint unsigned x, t, term, acc;
    for (longint unsigned i = 0; i <= TABLE_N; i++) begin
      x    = (i << 30) / TABLE_N;
      t    = (x * LN2_Q30_C) >> 30;
      term = ONE_Q30_C;
      acc  = ONE_Q30_C;
      for (longint unsigned k = 1; k <= 14; k++) begin
        term = ((term * t) >> 30) / k;
        acc += term;
      end
      exp2_rom[i] = acc;
    end
  end

  // 10^(dbz*4/70) * height in Q.8, via exp2 of a Q.16 exponent.
  function automatic longint unsigned layer_water_term(logic signed [11:0] dbz,
                                                       logic [15:0] height);
    longint          e28;
    longint unsigned biased, frac, pos, idx, w, lo, hi, mant, q;
    int              ie, sh;
    e28    = longint'(dbz) * longint'(SLOPE_Q24) + (longint'(32) <<< 28);
    biased = longint'(e28 + 2048) >> 12;
    ie     = int'(biased >> 16) - 32;
    frac   = biased & 64'hFFFF;
    pos    = frac * TABLE_N;
    idx    = pos >> 16;
    w      = pos & 64'hFFFF;
    if (idx > TABLE_N - 1) idx = TABLE_N - 1;
    lo   = exp2_rom[idx];
    hi   = exp2_rom[idx + 1];
    mant = lo + (((hi - lo) * w) >> 16);
    q    = mant * longint'(height);
    sh   = ie - 22;
    if (sh >= 0) return q << sh;
    if (-sh >= 64) return 0;
    return q >> (-sh);
  endfunction

  function automatic vil_result_t scaled_vil(longint unsigned total, logic clamped,
                                             logic [23:0] scale);
    longint unsigned r;
    vil_result_t     res;
    r = (total >> 32) * longint'(scale) + (((total & VIL_MAX) * longint'(scale)) >> 32);
    res.saturated = clamped;
    if (r > VIL_MAX) begin
      r             = VIL_MAX;
      res.saturated = 1'b1;
    end
    res.vil = r[VIL_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= SHOWN_LIMIT) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vil_result_t        want;
    longint unsigned    total;
    logic signed [11:0] dbz;
    if (!rst_ni) begin
      threshold_q = THRESHOLD_RESET;
      scale_q     = SCALE_RESET;
      column_sum  = 0;
      sum_clamped = 1'b0;
      expected_vil_q.delete();
      pending_o   = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_vil_q.size() == 0) begin
          flag_mismatch("unexpected result", 0, m_tdata_i);
        end else begin
          want = expected_vil_q.pop_front();
          if (m_tdata_i !== want.vil) flag_mismatch("vil", want.vil, m_tdata_i);
          if (m_tuser_i !== want.saturated) begin
            flag_mismatch("saturated", want.saturated, m_tuser_i);
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == ADDR_THRESHOLD) threshold_q = pwdata_i[11:0];
        else scale_q = pwdata_i[23:0];
      end
      if (s_tvalid_i && s_tready_i) begin
        dbz = s_tdata_i[11:0];
        if (dbz > threshold_q) begin
          total = column_sum + layer_water_term(dbz, s_tdata_i[27:12]);
          if (total < column_sum) begin
            total       = '1;
            sum_clamped = 1'b1;
          end
          column_sum = total;
        end
        if (s_tlast_i) begin
          expected_vil_q.push_back(scaled_vil(column_sum, sum_clamped, scale_q));
          column_sum  = 0;
          sum_clamped = 1'b0;
        end
      end
      pending_o = expected_vil_q.size();
    end
  end

endmodule

### tb/sv/vil_layer_accumulator_tb.sv
// Testbench top for the VIL layer accumulator: clock, reset, layer stimulus, register writes and verdict.
module vil_layer_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vla_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASE_ITEMS  = 205;
  localparam int unsigned PHASES       = 6;

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic [31:0]          s_tdata  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [VIL_W-1:0]     m_tdata;
  logic                 m_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int unsigned          fail_count;
  int unsigned          pending;

  int                   send_idle_pct = 33;
  int                   recv_idle_pct = 79;
  int unsigned          hold_requests = 0;
  int unsigned          holds_done    = 0;
  int unsigned          hold_left     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vil_layer_accumulator uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready)
  );

  vil_column_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    if (holds_done != hold_requests) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_layer(input logic [11:0] dbz, input logic [15:0] height,
                            input logic is_last);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {4'b0000, height, dbz};
    s_tlast  <= is_last;
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [11:0] pick_dbz();
    case ($urandom_range(9))
      0, 1:    return 12'($urandom);
      2:       return $urandom_range(1) ? 12'h7FF : 12'h800;
      default: return 12'($urandom_range(1440) - 320);
    endcase
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(7))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(2000, 100));
    endcase
  endfunction

  initial begin
    logic [11:0]  phase_thr   [PHASES] = '{12'h000, 12'h800, 12'd320, 12'h7FF, 12'hFFF, 12'd560};
    logic [23:0]  phase_scale [PHASES] = '{24'd3782387, 24'hFFFFFF, 24'd1, 24'd0, 24'd0,
                                          24'd3782387};
    int unsigned  items, len;
    logic         paused;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: saturation, threshold ties, zero height, multi-layer columns.
    send_layer(12'h7FF, 16'hFFFF, 1'b1);
    send_layer(12'h000, 16'd1000, 1'b1);
    send_layer(12'h001, 16'h0000, 1'b1);
    send_layer(12'h001, 16'h0001, 1'b1);
    send_layer(12'd800, 16'd1000, 1'b0);
    send_layer(12'd640, 16'd2000, 1'b0);
    send_layer(12'hFF0, 16'd500, 1'b1);
    send_layer(12'h800, 16'hFFFF, 1'b1);
    send_layer(12'd1120, 16'hFFFF, 1'b0);
    send_layer(12'd1120, 16'hFFFF, 1'b0);
    send_layer(12'd1120, 16'hFFFF, 1'b1);
    send_layer(12'd16, 16'd1000, 1'b1);
    send_layer(12'd35, 16'd1000, 1'b1);
    send_layer(12'd2000, 16'h0001, 1'b1);
    send_layer(12'h555, 16'hAAAA, 1'b1);
    send_layer(12'h555, 16'h5555, 1'b1);
    send_layer(12'hAAA, 16'h5555, 1'b0);
    send_layer(12'd400, 16'd300, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 4) phase_scale[ph] = 24'($urandom);
      drain_block();
      write_reg(REG_THRESHOLD, {{20{phase_thr[ph][11]}}, phase_thr[ph]});
      write_reg(REG_SCALE, {8'h00, phase_scale[ph]});

      if (phase_thr[ph] != 12'h7FF) send_layer(phase_thr[ph] + 12'd1, pick_height(), 1'b0);
      send_layer(phase_thr[ph], pick_height(), 1'b1);

      if (ph == 2 || ph == 4) hold_requests++;
      items  = 0;
      paused = 1'b0;
      while (items < PHASE_ITEMS) begin
        if (ph == 3 && !paused && items >= PHASE_ITEMS / 2) begin
          drain_block();
          paused = 1'b1;
        end
        len = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
        for (int j = 0; j < len; j++) begin
          send_layer(pick_dbz(), pick_height(), j == len - 1);
        end
        items += len;
      end
    end

    drain_block();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
